@@ src/rdir_pkg.sv @@
//------------------------------------------------------------------------------
// Refraction direction package
// Number formats, payload types and rounding helpers for the refraction
// direction pipeline.
//------------------------------------------------------------------------------
package rdir_pkg;

   // Component and ratio formats.
   localparam int COMP_WIDTH  = 16;
   localparam int FRAC_BITS   = 14;
   localparam int RATIO_WIDTH = 16;
   localparam int RATIO_FRAC  = 13;

   // Normalisation: the largest magnitude is shifted up to this bit.
   localparam int NRM_W   = 32;
   localparam int NRM_TOP = NRM_W - 2;
   localparam int SH_W    = $clog2(NRM_W);
   localparam int SUM_W   = 2 * NRM_W;
   localparam int LEN_W   = SUM_W / 2;

   // Division and unit vector.
   localparam int NUM_W = NRM_W + FRAC_BITS + 1;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int U_W   = FRAC_BITS + 2;

   // Intermediate widths.
   localparam int PRD_W = U_W + COMP_WIDTH;
   localparam int NC_W  = 2 * COMP_WIDTH;
   localparam int QV_W  = FRAC_BITS + 4;
   localparam int RR_W  = 2 * RATIO_WIDTH;
   localparam int RT_W  = RR_W + QV_W + 1;
   localparam int DS_W  = 2 * FRAC_BITS + 10;
   localparam int S_W   = DS_W / 2;
   localparam int A_LIM = 46;
   localparam int A_W   = A_LIM + 2;
   localparam int T1_W  = A_W + RATIO_WIDTH + 1;
   localparam int T2_W  = COMP_WIDTH + S_W + 1;
   localparam int WIDE_W = 96;

   typedef logic signed [COMP_WIDTH-1:0] comp_type;
   typedef logic        [RATIO_WIDTH-1:0] ratio_type;
   typedef logic signed [U_W-1:0]        uvec_type;
   typedef logic signed [PRD_W-1:0]      prod_type;
   typedef logic signed [NC_W-1:0]       nc_type;
   typedef logic signed [A_W-1:0]        avec_type;
   typedef logic signed [T1_W-1:0]       t1_type;
   typedef logic signed [T2_W-1:0]       t2_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;

   typedef struct packed {
      comp_type  view_x;
      comp_type  view_y;
      comp_type  view_z;
      comp_type  normal_x;
      comp_type  normal_y;
      comp_type  normal_z;
      ratio_type index_ratio;
   } req_type;

   typedef struct packed {
      comp_type out_x;
      comp_type out_y;
      comp_type out_z;
      logic     refracted;
   } rsp_type;

   // Side data carried alongside the length square root.
   typedef struct packed {
      logic [2:0]            neg;
      comp_type [2:0]        normal;
      ratio_type             ratio;
      logic [2:0][NRM_W-1:0] nmag;
      logic                  nonzero;
   } front_sb_type;

   // Side data carried alongside the divider.
   typedef struct packed {
      logic [2:0]     neg;
      comp_type [2:0] normal;
      ratio_type      ratio;
      logic           nonzero;
   } div_sb_type;

   // Side data carried alongside the second square root.
   typedef struct packed {
      avec_type [2:0] a;
      comp_type [2:0] normal;
      ratio_type      ratio;
      logic           good;
   } back_sb_type;

   // Divide by 2^k, rounding half away from zero.
   function automatic wide_type round_shr(wide_type x, int unsigned k);
      wide_type half;
      wide_type adj;
      half = wide_type'(1) <<< (k - 1);
      adj  = wide_type'(x < 0);
      return (x + half - adj) >>> k;
   endfunction

   function automatic wide_type clamp_wide(wide_type x, wide_type lo, wide_type hi);
      wide_type y;
      y = x;
      if (x < lo) begin
         y = lo;
      end else if (x > hi) begin
         y = hi;
      end
      return y;
   endfunction

   // Saturate to the signed component range.
   function automatic comp_type sat_comp(wide_type x);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (COMP_WIDTH - 1)) - wide_type'(1);
      lo = -hi - wide_type'(1);
      return comp_type'(clamp_wide(x, lo, hi));
   endfunction

endpackage

@@ src/rdir_isqrt.sv @@
//------------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; side data travels with each operand.
//------------------------------------------------------------------------------
module rdir_isqrt
   import rdir_pkg::*;
#(
   parameter int IN_W = 64,
   parameter int SB_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     radicand,
   input  logic [SB_W-1:0]     in_sb,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   root,
   output logic [SB_W-1:0]     out_sb
);

   localparam int STEPS = IN_W / 2;

   logic [IN_W-1:0] x_ff   [STEPS];
   logic [IN_W-1:0] r_ff   [STEPS];
   logic            vld_ff [STEPS];
   logic [SB_W-1:0] sb_ff  [STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      localparam logic [IN_W-1:0] STEP_BIT = IN_W'(1) << (IN_W - 2 - 2 * g);
      logic [IN_W-1:0] x_src;
      logic [IN_W-1:0] r_src;
      logic [IN_W-1:0] trial;
      logic            v_src;
      logic [SB_W-1:0] sb_src;

      if (g == 0) begin : g_first
         assign x_src  = radicand;
         assign r_src  = '0;
         assign v_src  = in_valid;
         assign sb_src = in_sb;
      end else begin : g_next
         assign x_src  = x_ff[g-1];
         assign r_src  = r_ff[g-1];
         assign v_src  = vld_ff[g-1];
         assign sb_src = sb_ff[g-1];
      end

      assign trial = r_src + STEP_BIT;

      always_ff @(posedge clock) begin
         if (en) begin
            if (x_src >= trial) begin
               x_ff[g] <= x_src - trial;
               r_ff[g] <= (r_src >> 1) + STEP_BIT;
            end else begin
               x_ff[g] <= x_src;
               r_ff[g] <= r_src >> 1;
            end
            sb_ff[g] <= sb_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= v_src;
         end
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign root      = r_ff[STEPS-1][IN_W/2-1:0];
   assign out_sb    = sb_ff[STEPS-1];

endmodule

@@ src/rdir_div.sv @@
//------------------------------------------------------------------------------
// Pipelined three-lane divider
// Restoring division of three numerators by a shared divisor, one quotient
// bit per stage.
//------------------------------------------------------------------------------
module rdir_div
   import rdir_pkg::*;
#(
   parameter int NUM_WD = 47,
   parameter int DEN_WD = 32,
   parameter int QW     = 15,
   parameter int SB_W   = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [2:0][NUM_WD-1:0] num,
   input  logic [DEN_WD-1:0]      den,
   input  logic [SB_W-1:0]        in_sb,
   output logic                   out_valid,
   output logic [2:0][QW-1:0]     quot,
   output logic [SB_W-1:0]        out_sb
);

   logic [2:0][NUM_WD-1:0] rem_ff [QW];
   logic [2:0][QW-1:0]     q_ff   [QW];
   logic [DEN_WD-1:0]      den_ff [QW];
   logic                   vld_ff [QW];
   logic [SB_W-1:0]        sb_ff  [QW];

   for (genvar g = 0; g < QW; g++) begin : g_step
      localparam int K = QW - 1 - g;
      logic [2:0][NUM_WD-1:0] rem_src;
      logic [2:0][QW-1:0]     q_src;
      logic [DEN_WD-1:0]      den_src;
      logic                   v_src;
      logic [SB_W-1:0]        sb_src;
      logic [NUM_WD-1:0]      den_sh;
      logic [2:0][NUM_WD-1:0] rem_in;
      logic [2:0][QW-1:0]     q_in;

      if (g == 0) begin : g_first
         assign rem_src = num;
         assign q_src   = '0;
         assign den_src = den;
         assign v_src   = in_valid;
         assign sb_src  = in_sb;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign q_src   = q_ff[g-1];
         assign den_src = den_ff[g-1];
         assign v_src   = vld_ff[g-1];
         assign sb_src  = sb_ff[g-1];
      end

      assign den_sh = NUM_WD'(den_src) << K;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (rem_src[i] >= den_sh) begin
               rem_in[i] = rem_src[i] - den_sh;
               q_in[i]   = {q_src[i][QW-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_src[i];
               q_in[i]   = {q_src[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            q_ff[g]   <= q_in;
            den_ff[g] <= den_src;
            sb_ff[g]  <= sb_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= v_src;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign quot      = q_ff[QW-1];
   assign out_sb    = sb_ff[QW-1];

endmodule

@@ src/rdir_outq.sv @@
//------------------------------------------------------------------------------
// Result buffer
// Two-entry output buffer: the head drives the response port and a skid
// entry lets the pipeline keep moving while a result waits.
//------------------------------------------------------------------------------
module rdir_outq
   import rdir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   output logic    space
);

   logic    head_v_ff, head_v_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop = head_v_ff && !rsp_stall;

   always_comb begin
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      head_in   = head_ff;
      skid_in   = skid_ff;
      if (pop) begin
         if (skid_v_ff) begin
            head_in   = skid_ff;
            head_v_in = 1'b1;
            skid_v_in = push;
            skid_in   = push_data;
         end else begin
            head_v_in = push;
            head_in   = push_data;
         end
      end else if (push) begin
         if (!head_v_ff) begin
            head_v_in = 1'b1;
            head_in   = push_data;
         end else begin
            skid_v_in = 1'b1;
            skid_in   = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = head_v_ff;
   assign rsp_data  = head_ff;
   assign space     = !skid_v_ff || !rsp_stall;

endmodule

@@ src/refraction_direction.sv @@
//------------------------------------------------------------------------------
// Refraction direction
// Streams rays through Snell's law: normalises the view vector, forms the
// cosine with the normal and returns the refracted direction, or reports
// total internal reflection.
//------------------------------------------------------------------------------
//
//   Channel   Ports                            Direction   Payload
//   request   req_valid, req_stall, req_data   in          req_type
//   response  rsp_valid, rsp_stall, rsp_data   out         rsp_type
//
// One request enters per clock cycle while req_stall is low, and each gives
// exactly one response. The pipeline contains the 32-stage length square root,
// the FRAC_BITS+1 stage divider and the FRAC_BITS+5 stage square root of
// the discriminant.
// Reset is synchronous and only clears the valid bits and the output buffer.
// A two-entry output buffer lets requests keep flowing while a response waits;
// once full, port stalled and a result waiting, the whole pipeline holds.
//
//------------------------------------------------------------------------------
module refraction_direction
   import rdir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Global advance: the pipeline moves unless its last stage holds a result
   // that the output buffer cannot take.
   logic en;
   logic space;
   logic p9_vld_ff;

   assign en        = !p9_vld_ff || space;
   assign req_stall = !en;

   // Stage 1: capture the request.
   logic    s1_vld_ff;
   req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_req_ff <= req_data;
      end
   end

   // Stage 2: component magnitudes and the largest of them.
   comp_type [2:0]             s1_view;
   comp_type [2:0]             s1_norm;
   logic [2:0][COMP_WIDTH-1:0] s2_mag_in, s2_mag_ff;
   logic [COMP_WIDTH-1:0]      s2_mx_in, s2_mx_ff;
   logic [2:0]                 s2_neg_in, s2_neg_ff;
   comp_type [2:0]             s2_n_ff;
   ratio_type                  s2_r_ff;
   logic                       s2_vld_ff;

   assign s1_view = {s1_req_ff.view_z, s1_req_ff.view_y, s1_req_ff.view_x};
   assign s1_norm = {s1_req_ff.normal_z, s1_req_ff.normal_y, s1_req_ff.normal_x};

   always_comb begin
      s2_mx_in = '0;
      for (int i = 0; i < 3; i++) begin
         s2_neg_in[i] = s1_view[i] < 0;
         s2_mag_in[i] = s2_neg_in[i] ? (~s1_view[i] + 1'b1) : s1_view[i];
         if (s2_mag_in[i] > s2_mx_in) begin
            s2_mx_in = s2_mag_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_mag_ff <= s2_mag_in;
         s2_mx_ff  <= s2_mx_in;
         s2_neg_ff <= s2_neg_in;
         s2_n_ff   <= s1_norm;
         s2_r_ff   <= s1_req_ff.index_ratio;
      end
   end

   // Stage 3: shift that brings the largest magnitude to bit NRM_TOP.
   logic [NRM_W-1:0]           s2_mx_ext;
   logic [SH_W-1:0]            s3_pos;
   logic [SH_W-1:0]            s3_sh_in, s3_sh_ff;
   logic [2:0][COMP_WIDTH-1:0] s3_mag_ff;
   logic [2:0]                 s3_neg_ff;
   comp_type [2:0]             s3_n_ff;
   ratio_type                  s3_r_ff;
   logic                       s3_nz_ff;
   logic                       s3_vld_ff;

   assign s2_mx_ext = NRM_W'(s2_mx_ff);

   always_comb begin
      s3_pos = '0;
      for (int i = 0; i < NRM_W; i++) begin
         if (s2_mx_ext[i]) begin
            s3_pos = SH_W'(i);
         end
      end
      if (s3_pos < SH_W'(NRM_TOP)) begin
         s3_sh_in = SH_W'(NRM_TOP) - s3_pos;
      end else begin
         s3_sh_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sh_ff  <= s3_sh_in;
         s3_mag_ff <= s2_mag_ff;
         s3_neg_ff <= s2_neg_ff;
         s3_n_ff   <= s2_n_ff;
         s3_r_ff   <= s2_r_ff;
         s3_nz_ff  <= s2_mx_ff != '0;
      end
   end

   // Stage 4: normalised magnitudes.
   logic [2:0][NRM_W-1:0] s4_nmag_in, s4_nmag_ff;
   logic [2:0]            s4_neg_ff;
   comp_type [2:0]        s4_n_ff;
   ratio_type             s4_r_ff;
   logic                  s4_nz_ff;
   logic                  s4_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_nmag_in[i] = NRM_W'(s3_mag_ff[i]) << s3_sh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_nmag_ff <= s4_nmag_in;
         s4_neg_ff  <= s3_neg_ff;
         s4_n_ff    <= s3_n_ff;
         s4_r_ff    <= s3_r_ff;
         s4_nz_ff   <= s3_nz_ff;
      end
   end

   // Stage 5: squares, one multiplier per axis.
   logic [2:0][SUM_W-1:0] s5_sq_in, s5_sq_ff;
   front_sb_type          s5_sb_in, s5_sb_ff;
   logic                  s5_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_sq_in[i] = SUM_W'(s4_nmag_ff[i]) * SUM_W'(s4_nmag_ff[i]);
      end
      s5_sb_in.neg     = s4_neg_ff;
      s5_sb_in.normal  = s4_n_ff;
      s5_sb_in.ratio   = s4_r_ff;
      s5_sb_in.nmag    = s4_nmag_ff;
      s5_sb_in.nonzero = s4_nz_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_sq_ff <= s5_sq_in;
         s5_sb_ff <= s5_sb_in;
      end
   end

   // Stage 6: squared length. It cannot overflow since each square is below 2^62.
   logic [SUM_W-1:0] s6_sum_ff;
   front_sb_type     s6_sb_ff;
   logic             s6_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s6_sum_ff <= s5_sq_ff[0] + s5_sq_ff[1] + s5_sq_ff[2];
         s6_sb_ff  <= s5_sb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   // Length of the normalised view vector.
   logic                             len_vld;
   logic [LEN_W-1:0]                 len;
   logic [$bits(front_sb_type)-1:0]  len_sb_raw;
   front_sb_type                     len_sb;

   rdir_isqrt #(
      .IN_W (SUM_W),
      .SB_W ($bits(front_sb_type))
   ) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_vld_ff),
      .radicand  (s6_sum_ff),
      .in_sb     (s6_sb_ff),
      .out_valid (len_vld),
      .root      (len),
      .out_sb    (len_sb_raw)
   );

   assign len_sb = front_sb_type'(len_sb_raw);

   // Stage 7: numerators for the unit vector, rounded half up.
   logic [2:0][NUM_W-1:0] s7_num_in, s7_num_ff;
   logic [LEN_W-1:0]      s7_len_ff;
   div_sb_type            s7_sb_in, s7_sb_ff;
   logic                  s7_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_num_in[i] = (NUM_W'(len_sb.nmag[i]) << FRAC_BITS) + NUM_W'(len >> 1);
      end
      s7_sb_in.neg     = len_sb.neg;
      s7_sb_in.normal  = len_sb.normal;
      s7_sb_in.ratio   = len_sb.ratio;
      s7_sb_in.nonzero = len_sb.nonzero;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_num_ff <= s7_num_in;
         s7_len_ff <= len;
         s7_sb_ff  <= s7_sb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff <= len_vld;
      end
   end

   // Unit vector magnitudes. Each quotient is at most one, as no component
   // exceeds the length.
   logic                           div_vld;
   logic [2:0][Q_W-1:0]            quot;
   logic [$bits(div_sb_type)-1:0]  div_sb_raw;
   div_sb_type                     div_sb;

   rdir_div #(
      .NUM_WD (NUM_W),
      .DEN_WD (LEN_W),
      .QW     (Q_W),
      .SB_W   ($bits(div_sb_type))
   ) u_unit_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s7_vld_ff),
      .num       (s7_num_ff),
      .den       (s7_len_ff),
      .in_sb     (s7_sb_ff),
      .out_valid (div_vld),
      .quot      (quot),
      .out_sb    (div_sb_raw)
   );

   assign div_sb = div_sb_type'(div_sb_raw);

   // P1: signed unit vector.
   uvec_type [2:0] p1_u_in, p1_u_ff;
   comp_type [2:0] p1_n_ff;
   ratio_type      p1_r_ff;
   logic           p1_nz_ff;
   logic           p1_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_u_in[i] = div_sb.neg[i] ? (U_W'(0) - U_W'(quot[i])) : U_W'(quot[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_u_ff  <= p1_u_in;
         p1_n_ff  <= div_sb.normal;
         p1_r_ff  <= div_sb.ratio;
         p1_nz_ff <= div_sb.nonzero;
      end
   end

   // P2: dot product terms and the squared ratio.
   prod_type [2:0]  p2_prod_in, p2_prod_ff;
   logic [RR_W-1:0] p2_rr_ff;
   uvec_type [2:0]  p2_u_ff;
   comp_type [2:0]  p2_n_ff;
   ratio_type       p2_r_ff;
   logic            p2_nz_ff;
   logic            p2_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p2_prod_in[i] = PRD_W'(p1_u_ff[i]) * PRD_W'(p1_n_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_prod_ff <= p2_prod_in;
         p2_rr_ff   <= RR_W'(p1_r_ff) * RR_W'(p1_r_ff);
         p2_u_ff    <= p1_u_ff;
         p2_n_ff    <= p1_n_ff;
         p2_r_ff    <= p1_r_ff;
         p2_nz_ff   <= p1_nz_ff;
      end
   end

   // P3: cosine c, rounded and saturated to the component range.
   wide_type        p3_dot;
   comp_type        p3_c_ff;
   logic [RR_W-1:0] p3_rr_ff;
   uvec_type [2:0]  p3_u_ff;
   comp_type [2:0]  p3_n_ff;
   ratio_type       p3_r_ff;
   logic            p3_nz_ff;
   logic            p3_vld_ff;

   assign p3_dot = wide_type'(p2_prod_ff[0]) + wide_type'(p2_prod_ff[1])
                 + wide_type'(p2_prod_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         p3_c_ff  <= sat_comp(round_shr(p3_dot, FRAC_BITS));
         p3_rr_ff <= p2_rr_ff;
         p3_u_ff  <= p2_u_ff;
         p3_n_ff  <= p2_n_ff;
         p3_r_ff  <= p2_r_ff;
         p3_nz_ff <= p2_nz_ff;
      end
   end

   // P4: c squared and the normal scaled by c.
   nc_type          p4_cc_ff;
   nc_type [2:0]    p4_nc_in, p4_nc_ff;
   logic [RR_W-1:0] p4_rr_ff;
   uvec_type [2:0]  p4_u_ff;
   comp_type [2:0]  p4_n_ff;
   ratio_type       p4_r_ff;
   logic            p4_nz_ff;
   logic            p4_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p4_nc_in[i] = NC_W'(p3_n_ff[i]) * NC_W'(p3_c_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p4_cc_ff <= NC_W'(p3_c_ff) * NC_W'(p3_c_ff);
         p4_nc_ff <= p4_nc_in;
         p4_rr_ff <= p3_rr_ff;
         p4_u_ff  <= p3_u_ff;
         p4_n_ff  <= p3_n_ff;
         p4_r_ff  <= p3_r_ff;
         p4_nz_ff <= p3_nz_ff;
      end
   end

   // P5: q = 1 - c^2 with c^2 capped at four, and the tangential part
   // a = u - n c clamped to +-2^46.
   wide_type                 p5_c2;
   wide_type                 p5_c2_cap;
   wide_type                 p5_q;
   wide_type                 p5_a_lim;
   logic signed [QV_W-1:0]   p5_q_ff;
   avec_type [2:0]           p5_a_in, p5_a_ff;
   logic [RR_W-1:0]          p5_rr_ff;
   comp_type [2:0]           p5_n_ff;
   ratio_type                p5_r_ff;
   logic                     p5_nz_ff;
   logic                     p5_vld_ff;

   assign p5_c2_cap = wide_type'(4) <<< FRAC_BITS;
   assign p5_a_lim  = wide_type'(1) <<< A_LIM;

   always_comb begin
      p5_c2 = round_shr(wide_type'(p4_cc_ff), FRAC_BITS);
      if (p5_c2 > p5_c2_cap) begin
         p5_c2 = p5_c2_cap;
      end
      p5_q = (wide_type'(1) <<< FRAC_BITS) - p5_c2;
      for (int i = 0; i < 3; i++) begin
         p5_a_in[i] = A_W'(clamp_wide(wide_type'(p4_u_ff[i])
                        - round_shr(wide_type'(p4_nc_ff[i]), FRAC_BITS),
                        -p5_a_lim, p5_a_lim));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p5_q_ff  <= QV_W'(p5_q);
         p5_a_ff  <= p5_a_in;
         p5_rr_ff <= p4_rr_ff;
         p5_n_ff  <= p4_n_ff;
         p5_r_ff  <= p4_r_ff;
         p5_nz_ff <= p4_nz_ff;
      end
   end

   // P6: r^2 * q.
   logic signed [RT_W-1:0] p6_rr_ext;
   logic signed [RT_W-1:0] p6_q_ext;
   logic signed [RT_W-1:0] p6_rt_ff;
   avec_type [2:0]         p6_a_ff;
   comp_type [2:0]         p6_n_ff;
   ratio_type              p6_r_ff;
   logic                   p6_nz_ff;
   logic                   p6_vld_ff;

   assign p6_rr_ext = RT_W'(p5_rr_ff);
   assign p6_q_ext  = RT_W'(p5_q_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p6_rt_ff <= p6_rr_ext * p6_q_ext;
         p6_a_ff  <= p5_a_ff;
         p6_n_ff  <= p5_n_ff;
         p6_r_ff  <= p5_r_ff;
         p6_nz_ff <= p5_nz_ff;
      end
   end

   // P7: discriminant d = 1 - r^2 q. A negative d is total internal
   // reflection; it and a zero view vector both clear the good flag.
   wide_type         p7_d;
   logic             p7_good;
   logic [DS_W-1:0]  p7_ds_in, p7_ds_ff;
   back_sb_type      p7_sb_in, p7_sb_ff;
   logic             p7_vld_ff;

   always_comb begin
      p7_d    = (wide_type'(1) <<< FRAC_BITS)
              - round_shr(wide_type'(p6_rt_ff), 2 * RATIO_FRAC);
      p7_good = p6_nz_ff && (p7_d >= 0);
      if (p7_good) begin
         p7_ds_in = DS_W'(p7_d <<< FRAC_BITS);
      end else begin
         p7_ds_in = '0;
      end
      p7_sb_in.a      = p6_a_ff;
      p7_sb_in.normal = p6_n_ff;
      p7_sb_in.ratio  = p6_r_ff;
      p7_sb_in.good   = p7_good;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p7_ds_ff <= p7_ds_in;
         p7_sb_ff <= p7_sb_in;
      end
   end

   // Square root of the discriminant.
   logic                             sd_vld;
   logic [S_W-1:0]                   sd;
   logic [$bits(back_sb_type)-1:0]   sd_sb_raw;
   back_sb_type                      sd_sb;

   rdir_isqrt #(
      .IN_W (DS_W),
      .SB_W ($bits(back_sb_type))
   ) u_disc_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p7_vld_ff),
      .radicand  (p7_ds_ff),
      .in_sb     (p7_sb_ff),
      .out_valid (sd_vld),
      .root      (sd),
      .out_sb    (sd_sb_raw)
   );

   assign sd_sb = back_sb_type'(sd_sb_raw);

   // P8: r a and n sqrt(d), one multiplier each per axis.
   t1_type [2:0]       p8_t1_in, p8_t1_ff;
   t2_type [2:0]       p8_t2_in, p8_t2_ff;
   logic signed [T1_W-1:0] p8_r_ext;
   logic signed [T2_W-1:0] p8_s_ext;
   logic               p8_good_ff;
   logic               p8_vld_ff;

   assign p8_r_ext = T1_W'(sd_sb.ratio);
   assign p8_s_ext = T2_W'(sd);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p8_t1_in[i] = p8_r_ext * T1_W'(sd_sb.a[i]);
         p8_t2_in[i] = T2_W'(sd_sb.normal[i]) * p8_s_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p8_t1_ff   <= p8_t1_in;
         p8_t2_ff   <= p8_t2_in;
         p8_good_ff <= sd_sb.good;
      end
   end

   // P9: final rounding, difference and saturation; zero when no refraction.
   comp_type [2:0] p9_res;
   rsp_type        p9_rsp_in, p9_rsp_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (p8_good_ff) begin
            p9_res[i] = sat_comp(round_shr(wide_type'(p8_t1_ff[i]), RATIO_FRAC)
                                 - round_shr(wide_type'(p8_t2_ff[i]), FRAC_BITS));
         end else begin
            p9_res[i] = '0;
         end
      end
      p9_rsp_in.out_x     = p9_res[0];
      p9_rsp_in.out_y     = p9_res[1];
      p9_rsp_in.out_z     = p9_res[2];
      p9_rsp_in.refracted = p8_good_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p9_rsp_ff <= p9_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
         p6_vld_ff <= 1'b0;
         p7_vld_ff <= 1'b0;
         p8_vld_ff <= 1'b0;
         p9_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= div_vld;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
         p6_vld_ff <= p5_vld_ff;
         p7_vld_ff <= p6_vld_ff;
         p8_vld_ff <= sd_vld;
         p9_vld_ff <= p8_vld_ff;
      end
   end

   // Output buffer.
   rdir_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (p9_vld_ff && en),
      .push_data (p9_rsp_ff),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .space     (space)
   );

endmodule
